// ===== rtl/core/sopl_pkg.sv =====
// Shared types, constants and helper functions of the sparse octree point lookup.
`timescale 1ns / 1ps

package sopl_pkg;

  // Fixed sizes of the tree and of the fields.
  localparam int unsigned CHILD_INDEX_BITS = 20;
  localparam int unsigned MAX_DEPTH        = 16;
  localparam int unsigned FRACTION_BITS    = 8;
  localparam int unsigned COORD_BITS       = 16;
  localparam int unsigned ADDR_BITS        = 12;
  localparam int unsigned DEPTH_BITS       = 5;
  localparam int unsigned LEVEL_BITS       = 4;
  localparam int unsigned CLOSE_BITS       = FRACTION_BITS + 1;
  localparam logic [FRACTION_BITS-1:0] FRAC_HALF =
    FRACTION_BITS'(1 << (FRACTION_BITS - 1));
  localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = 5'd8;

  // Operation codes of the input beat.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Axis codes used in the nearest-first order.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic                        operation;
    logic [ADDR_BITS-1:0]        node_address;
    logic [7:0]                  node_child_mask;
    logic [CHILD_INDEX_BITS-1:0] node_first_child;
    logic [COORD_BITS-1:0]       voxel_x;
    logic [COORD_BITS-1:0]       voxel_y;
    logic [COORD_BITS-1:0]       voxel_z;
    logic [FRACTION_BITS-1:0]    frac_x;
    logic [FRACTION_BITS-1:0]    frac_y;
    logic [FRACTION_BITS-1:0]    frac_z;
    logic                        check_neighbours;
  } cmd_t;

  typedef struct packed {
    logic                        found;
    logic [CHILD_INDEX_BITS-1:0] leaf_index;
    logic [2:0]                  neighbour_tried;
  } res_t;

  // One node of the store.
  typedef struct packed {
    logic [7:0]                  child_mask;
    logic [CHILD_INDEX_BITS-1:0] first_child;
  } node_t;

  // Write and read request to the node store.
  typedef struct packed {
    logic                        we;
    logic [CHILD_INDEX_BITS-1:0] waddr;
    node_t                       wdata;
    logic                        re;
    logic [CHILD_INDEX_BITS-1:0] raddr;
  } store_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CAND,
    ST_WALK
  } state_e;

  // Number of set mask bits below the given child.
  function automatic logic [3:0] count_below(input logic [7:0] mask, input logic [2:0] child);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 0; k < 8; k++) begin
      if (3'(k) < child) begin
        n = n + {3'd0, mask[k]};
      end
    end
    return n;
  endfunction

  // Distance of a fraction to the nearer cell face.
  function automatic logic [CLOSE_BITS-1:0] closeness(input logic [FRACTION_BITS-1:0] f);
    logic [CLOSE_BITS-1:0] c;
    if (f < FRAC_HALF) begin
      c = {1'b0, f};
    end else begin
      c = {FRAC_HALF, 1'b0} - {1'b0, f};
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/sopl_node_store.sv =====
// Node store: one synchronous memory with one write and one registered read port.
`timescale 1ns / 1ps

module sopl_node_store #(
  parameter int unsigned NODE_COUNT = 4096
) (
  input  logic                clk_i,
  input  sopl_pkg::store_req_t req_i,
  output sopl_pkg::node_t     rd_data_o
);

  localparam int unsigned AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  sopl_pkg::node_t mem [NODE_COUNT];
  sopl_pkg::node_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
  end

  // Registered read port: the data appear in the cycle after the read request.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr[AW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/sparse_octree_point_lookup.sv =====
// Top level of the sparse voxel octree point lookup with nearest-neighbour retry.
//
//   channel   ports                      direction  handshake
//   command   start, busy, cmd_i         in         beat taken when start and not busy
//   result    done_o, result_o           out        one-cycle strobe, no back-pressure
//   config    cfg_we_i, cfg_wdata_i      in         leaf_depth written when cfg_we_i
//
// A node write's result strobes in the cycle after the beat.
// A lookup forms each candidate voxel in ST_CAND, then does one node-store read per
// tree level in ST_WALK, each read waiting on the one before through the store; a
// lookup tries up to 8 candidates when check_neighbours is set.
// A voxel outside the grid gives its result in the cycle after the beat.
// Reset is asynchronous and active low; it clears control state and sets the depth
// to 8, while the node store holds whatever was written. Results cannot be stalled.
`timescale 1ns / 1ps

module sparse_octree_point_lookup #(
  parameter int unsigned NODE_COUNT = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  sopl_pkg::cmd_t                  cmd_i,
  output logic                            done_o,
  output sopl_pkg::res_t                  result_o,
  input  logic                            cfg_we_i,
  input  logic [sopl_pkg::DEPTH_BITS-1:0] cfg_wdata_i
);

  localparam int unsigned CB = sopl_pkg::COORD_BITS;
  localparam int unsigned IB = sopl_pkg::CHILD_INDEX_BITS;
  localparam int unsigned LB = sopl_pkg::LEVEL_BITS;
  localparam int unsigned DB = sopl_pkg::DEPTH_BITS;
  localparam int unsigned KB = sopl_pkg::CLOSE_BITS;

  // Control registers.
  sopl_pkg::state_e state_q, state_d;
  logic [DB-1:0]    leaf_depth_q;
  logic             done_q, done_d;
  logic [2:0]       cand_q, cand_d;

  // Payload registers.
  logic [2:0][CB-1:0] pos_q, pos_d;
  logic [2:0][CB-1:0] vox_q, vox_d;
  logic [CB-1:0]      lim_q, lim_d;
  logic [2:0]         neg_q, neg_d;
  logic [1:0]         ord0_q, ord0_d, ord1_q, ord1_d, ord2_q, ord2_d;
  logic               chk_q, chk_d;
  logic [LB-1:0]      top_q, top_d;
  logic [LB-1:0]      bit_q, bit_d;
  sopl_pkg::res_t     res_q, res_d;

  sopl_pkg::store_req_t req;
  sopl_pkg::node_t      rd_node;

  // Combinational helpers.
  logic [DB-1:0]      depth_eff;
  logic [CB-1:0]      lim_new;
  logic [2:0][CB-1:0] pos_in;
  logic [2:0][KB-1:0] close_v;
  logic [1:0]         o0, o1, ax_a, ax_b;
  logic [2:0]         move;
  logic [2:0][CB-1:0] vox_new;
  logic               in_grid;
  logic [2:0]         child;
  logic [IB-1:0]      next_idx;
  logic               accept;

  assign accept = start && !busy;

  sopl_node_store #(
    .NODE_COUNT(NODE_COUNT)
  ) u_store (
    .clk_i    (clk_i),
    .req_i    (req),
    .rd_data_o(rd_node)
  );

  // Clamp the configured depth and derive the largest coordinate in the grid.
  always_comb begin
    depth_eff = leaf_depth_q;
    if (leaf_depth_q == '0) begin
      depth_eff = DB'(1);
    end else if (leaf_depth_q > DB'(sopl_pkg::MAX_DEPTH)) begin
      depth_eff = DB'(sopl_pkg::MAX_DEPTH);
    end
    lim_new = CB'(((CB+1)'(1) << depth_eff) - (CB+1)'(1));
  end

  // Nearest-first axis order from the fractions of the incoming beat.
  always_comb begin
    pos_in[0]  = cmd_i.voxel_x;
    pos_in[1]  = cmd_i.voxel_y;
    pos_in[2]  = cmd_i.voxel_z;
    close_v[0] = sopl_pkg::closeness(cmd_i.frac_x);
    close_v[1] = sopl_pkg::closeness(cmd_i.frac_y);
    close_v[2] = sopl_pkg::closeness(cmd_i.frac_z);
    o0 = sopl_pkg::AXIS_X;
    if (close_v[1] < close_v[o0]) begin
      o0 = sopl_pkg::AXIS_Y;
    end
    if (close_v[2] < close_v[o0]) begin
      o0 = sopl_pkg::AXIS_Z;
    end
    case (o0)
      sopl_pkg::AXIS_X: begin
        ax_a = sopl_pkg::AXIS_Y;
        ax_b = sopl_pkg::AXIS_Z;
      end
      sopl_pkg::AXIS_Y: begin
        ax_a = sopl_pkg::AXIS_Z;
        ax_b = sopl_pkg::AXIS_X;
      end
      default: begin
        ax_a = sopl_pkg::AXIS_X;
        ax_b = sopl_pkg::AXIS_Y;
      end
    endcase
    o1 = (close_v[ax_b] < close_v[ax_a]) ? ax_b : ax_a;
  end

  // Candidate voxel: step the selected axes and flag a step off the grid.
  always_comb begin
    in_grid = 1'b1;
    for (int a = 0; a < 3; a++) begin
      move[a] = (cand_q[0] && (ord0_q == 2'(a))) ||
                (cand_q[1] && (ord1_q == 2'(a))) ||
                (cand_q[2] && (ord2_q == 2'(a)));
      vox_new[a] = pos_q[a];
      if (move[a]) begin
        if (neg_q[a]) begin
          if (pos_q[a] == '0) begin
            in_grid = 1'b0;
          end else begin
            vox_new[a] = pos_q[a] - CB'(1);
          end
        end else begin
          if (pos_q[a] == lim_q) begin
            in_grid = 1'b0;
          end else begin
            vox_new[a] = pos_q[a] + CB'(1);
          end
        end
      end
    end
  end

  // Child slot of the current level and the index it leads to.
  always_comb begin
    child    = {vox_q[2][bit_q], vox_q[1][bit_q], vox_q[0][bit_q]};
    next_idx = rd_node.first_child +
               IB'(sopl_pkg::count_below(rd_node.child_mask, child));
  end

  // Next state, store requests and result.
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cand_d  = cand_q;
    pos_d   = pos_q;
    vox_d   = vox_q;
    lim_d   = lim_q;
    neg_d   = neg_q;
    ord0_d  = ord0_q;
    ord1_d  = ord1_q;
    ord2_d  = ord2_q;
    chk_d   = chk_q;
    top_d   = top_q;
    bit_d   = bit_q;
    res_d   = res_q;

    req.we          = 1'b0;
    req.waddr       = IB'(cmd_i.node_address);
    req.wdata       = '{child_mask: cmd_i.node_child_mask,
                        first_child: cmd_i.node_first_child};
    req.re          = 1'b0;
    req.raddr       = '0;

    case (state_q)
      sopl_pkg::ST_IDLE: begin
        if (accept) begin
          res_d = '0;
          if (cmd_i.operation == sopl_pkg::OP_WRITE) begin
            req.we = (32'(cmd_i.node_address) < 32'(NODE_COUNT));
            done_d = 1'b1;
          end else begin
            pos_d  = pos_in;
            lim_d  = lim_new;
            neg_d  = {cmd_i.frac_z < sopl_pkg::FRAC_HALF,
                      cmd_i.frac_y < sopl_pkg::FRAC_HALF,
                      cmd_i.frac_x < sopl_pkg::FRAC_HALF};
            ord0_d = o0;
            ord1_d = o1;
            ord2_d = 2'(2'd3 - o0 - o1);
            chk_d  = cmd_i.check_neighbours;
            top_d  = LB'(depth_eff - DB'(1));
            cand_d = '0;
            if ((pos_in[0] > lim_new) || (pos_in[1] > lim_new) ||
                (pos_in[2] > lim_new)) begin
              done_d = 1'b1;
            end else begin
              state_d = sopl_pkg::ST_CAND;
            end
          end
        end
      end

      sopl_pkg::ST_CAND: begin
        if (in_grid) begin
          // Start the descent at the root node.
          vox_d     = vox_new;
          bit_d     = top_q;
          req.re    = 1'b1;
          req.raddr = '0;
          state_d   = sopl_pkg::ST_WALK;
        end else if (!chk_q || (cand_q == 3'd7)) begin
          done_d  = 1'b1;
          state_d = sopl_pkg::ST_IDLE;
        end else begin
          cand_d = cand_q + 3'd1;
        end
      end

      sopl_pkg::ST_WALK: begin
        if (rd_node.child_mask[child] && (bit_q == '0)) begin
          // Leaf reached.
          res_d.found           = 1'b1;
          res_d.leaf_index      = next_idx;
          res_d.neighbour_tried = cand_q;
          done_d                = 1'b1;
          state_d               = sopl_pkg::ST_IDLE;
        end else if (rd_node.child_mask[child] && (32'(next_idx) < 32'(NODE_COUNT))) begin
          // Inner node: read it for the next level.
          req.re    = 1'b1;
          req.raddr = next_idx;
          bit_d     = bit_q - LB'(1);
        end else if (!chk_q || (cand_q == 3'd7)) begin
          done_d  = 1'b1;
          state_d = sopl_pkg::ST_IDLE;
        end else begin
          cand_d  = cand_q + 3'd1;
          state_d = sopl_pkg::ST_CAND;
        end
      end

      default: begin
        state_d = sopl_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sopl_pkg::ST_IDLE;
      done_q       <= 1'b0;
      cand_q       <= '0;
      leaf_depth_q <= sopl_pkg::DEPTH_RESET;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cand_q  <= cand_d;
      if (cfg_we_i) begin
        leaf_depth_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    vox_q  <= vox_d;
    lim_q  <= lim_d;
    neg_q  <= neg_d;
    ord0_q <= ord0_d;
    ord1_q <= ord1_d;
    ord2_q <= ord2_d;
    chk_q  <= chk_d;
    top_q  <= top_d;
    bit_q  <= bit_d;
    res_q  <= res_d;
  end

  assign busy     = (state_q != sopl_pkg::ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
